// ----- rtl/pocs_pkg.sv -----
// Shared types, codes and defaults of the precedence order check and sort block.
package pocs_pkg;

    localparam int PAGE_W = 7;
    localparam int CMD_W = 2;

    localparam int PAGE_RANGE_DEF = 128;
    localparam int MAX_LEN_DEF = 32;
    localparam int MAX_PASSES_DEF = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_RULE = 2'd0,
        CMD_APPEND   = 2'd1,
        CMD_CLEAR    = 2'd2
    } command_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PAGE_W-1:0] page_a;
        logic [PAGE_W-1:0] page_b;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              end_of_run;
        logic              was_ordered;
        logic [PAGE_W-1:0] middle_page;
        logic              overflow;
        logic              unsettled;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RULE_WR,
        ST_CHK_ROW,
        ST_CHK_SCAN,
        ST_SRT_ROW,
        ST_SRT_SCAN,
        ST_MID,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic clr_init;
        logic mem_clr;
        logic rule_rd;
        logic rule_wr;
        logic append;
        logic chk_init;
        logic pass_init;
        logic row_fetch;
        logic scan;
        logic pos_next;
        logic pass_done;
        logic set_unsettled;
        logic unsettled_val;
        logic mid_fetch;
        logic out_init;
        logic out_load;
        logic seq_done;
    } ctl_cmd_t;

    typedef struct packed {
        logic             in_valid;
        logic [CMD_W-1:0] in_cmd;
        logic             in_last;
        logic             rule_ok;
        logic             clr_last;
        logic             row_skip;
        logic             hit;
        logic             q_last;
        logic             pos_last;
        logic             swapped;
        logic             pass_limit;
        logic             out_free;
    } ctl_status_t;

endpackage

// ----- rtl/pocs_chan_if.sv -----
// Valid/ready channel carrying one item per handshake.
interface pocs_chan_if #(parameter type item_t = logic);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/pocs_dp.sv -----
// Datapath: rule matrix memory, page list, scan counters and result register.
module pocs_dp #(
    parameter int PAGE_RANGE = pocs_pkg::PAGE_RANGE_DEF,
    parameter int MAX_LEN = pocs_pkg::MAX_LEN_DEF,
    parameter int MAX_PASSES = pocs_pkg::MAX_PASSES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    pocs_chan_if.sink            items,
    pocs_chan_if.source          results,
    input  pocs_pkg::ctl_cmd_t   cmd,
    output pocs_pkg::ctl_status_t st
);

    localparam int AW = $clog2(PAGE_RANGE);
    localparam int LW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = $clog2(MAX_PASSES + 1);
    localparam int PGW = pocs_pkg::PAGE_W;

    // Rule matrix: one row per earlier page, one bit per later page.
    logic [PAGE_RANGE-1:0] rule_mem [PAGE_RANGE];
    logic [PAGE_RANGE-1:0] row_reg;
    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [PAGE_RANGE-1:0] wr_data;

    logic [PGW-1:0] list_reg [MAX_LEN];
    logic [CW-1:0]  count_reg;
    logic           ovf_reg;
    logic [AW-1:0]  clr_idx_reg;
    logic [AW-1:0]  a_reg;
    logic [PGW-1:0] b_reg;
    logic [CW-1:0]  pos_reg;
    logic [AW-1:0]  q_reg;
    logic [PGW-1:0] cur_reg;
    logic           rowvalid_reg;
    logic           sorting_reg;
    logic           ordered_reg;
    logic           swapped_reg;
    logic           unsettled_reg;
    logic [PW-1:0]  passes_reg;
    logic [PGW-1:0] mid_reg;
    logic           out_valid_reg;
    pocs_pkg::out_item_t out_reg;

    logic [LW-1:0]  pos_idx;
    logic [PGW-1:0] pos_page;
    logic           found;
    logic [LW-1:0]  hit_idx;
    logic           hit;
    logic           swap_now;
    logic           pos_last;

    assign pos_idx = pos_reg[LW-1:0];
    assign pos_page = list_reg[pos_idx];

    assign mem_we = cmd.mem_clr | cmd.rule_wr;
    assign mem_re = cmd.rule_rd | cmd.row_fetch;
    assign wr_addr = cmd.mem_clr ? clr_idx_reg : a_reg;
    assign wr_data = cmd.mem_clr ? '0
                   : (row_reg | ({{(PAGE_RANGE-1){1'b0}}, 1'b1} << b_reg));
    assign rd_addr = cmd.rule_rd ? AW'(items.data.page_a) : AW'(pos_page);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rule_mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            row_reg <= rule_mem[rd_addr];
        end
    end

    // The earliest position holding the page under scan, below the current
    // position when sorting and up to it when checking.
    always_comb
    begin
        found = 1'b0;
        hit_idx = '0;
        for (int k = MAX_LEN - 1; k >= 0; k--)
        begin
            if ((32'(list_reg[k]) == 32'(q_reg))
                && (sorting_reg ? (CW'(k) < pos_reg) : (CW'(k) <= pos_reg)))
            begin
                found = 1'b1;
                hit_idx = LW'(k);
            end
        end
    end

    assign hit = rowvalid_reg & row_reg[q_reg] & found;
    assign swap_now = cmd.scan & hit & sorting_reg;
    assign pos_last = (pos_reg + CW'(1)) == count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg <= 1'b0;
            clr_idx_reg <= '0;
            a_reg <= '0;
            b_reg <= '0;
            pos_reg <= '0;
            q_reg <= '0;
            cur_reg <= '0;
            rowvalid_reg <= 1'b0;
            sorting_reg <= 1'b0;
            ordered_reg <= 1'b1;
            swapped_reg <= 1'b0;
            unsettled_reg <= 1'b0;
            passes_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_init)
            begin
                clr_idx_reg <= '0;
            end
            else if (cmd.mem_clr)
            begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end
            if (cmd.rule_rd)
            begin
                a_reg <= AW'(items.data.page_a);
                b_reg <= items.data.page_b;
            end
            if (cmd.append)
            begin
                if (count_reg < CW'(MAX_LEN))
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.chk_init)
            begin
                pos_reg <= '0;
                sorting_reg <= 1'b0;
                ordered_reg <= 1'b1;
                unsettled_reg <= 1'b0;
                passes_reg <= '0;
            end
            if (cmd.pass_init)
            begin
                pos_reg <= '0;
                sorting_reg <= 1'b1;
                swapped_reg <= 1'b0;
            end
            if (cmd.row_fetch)
            begin
                cur_reg <= pos_page;
                q_reg <= '0;
                rowvalid_reg <= 32'(pos_page) < 32'(PAGE_RANGE);
            end
            if (cmd.scan)
            begin
                q_reg <= q_reg + AW'(1);
                if (hit && sorting_reg)
                begin
                    cur_reg <= PGW'(q_reg);
                    // A swap in the last scan cycle belongs to the pass just ending.
                    if (!cmd.pass_init)
                    begin
                        swapped_reg <= 1'b1;
                    end
                end
                else if (hit)
                begin
                    ordered_reg <= 1'b0;
                end
            end
            if (cmd.pos_next)
            begin
                pos_reg <= pos_reg + CW'(1);
            end
            if (cmd.pass_done)
            begin
                passes_reg <= passes_reg + PW'(1);
            end
            if (cmd.set_unsettled)
            begin
                unsettled_reg <= cmd.unsettled_val;
            end
            if (cmd.out_init)
            begin
                pos_reg <= '0;
            end
            if (cmd.out_load)
            begin
                pos_reg <= pos_reg + CW'(1);
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.seq_done)
            begin
                count_reg <= '0;
                ovf_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append && (count_reg < CW'(MAX_LEN)))
        begin
            list_reg[count_reg[LW-1:0]] <= items.data.page_a;
        end
        if (swap_now)
        begin
            list_reg[hit_idx] <= cur_reg;
            list_reg[pos_idx] <= PGW'(q_reg);
        end
        if (cmd.mid_fetch)
        begin
            mid_reg <= list_reg[LW'(count_reg >> 1)];
        end
        if (cmd.out_load)
        begin
            out_reg.page <= pos_page;
            out_reg.end_of_run <= pos_last;
            out_reg.was_ordered <= ordered_reg;
            out_reg.middle_page <= mid_reg;
            out_reg.overflow <= ovf_reg;
            out_reg.unsettled <= unsettled_reg;
        end
    end

    assign items.ready = cmd.in_ready;
    assign results.valid = out_valid_reg;
    assign results.data = out_reg;

    assign st.in_valid = items.valid;
    assign st.in_cmd = items.data.command;
    assign st.in_last = items.data.last;
    assign st.rule_ok = (32'(items.data.page_a) < 32'(PAGE_RANGE))
                      && (32'(items.data.page_b) < 32'(PAGE_RANGE));
    assign st.clr_last = clr_idx_reg == AW'(PAGE_RANGE - 1);
    assign st.row_skip = !rowvalid_reg || (row_reg == '0);
    assign st.hit = hit;
    assign st.q_last = q_reg == AW'(PAGE_RANGE - 1);
    assign st.pos_last = pos_last;
    assign st.swapped = swapped_reg;
    assign st.pass_limit = (32'(passes_reg) + 32'd1) >= 32'(MAX_PASSES);
    assign st.out_free = !out_valid_reg || results.ready;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(MAX_LEN))
        else $error("page count beyond list length");
    a_swap_below: assert property (@(posedge clk) disable iff (!rst_n)
        swap_now |-> (32'(hit_idx) < 32'(pos_reg)))
        else $error("swap partner not below current position");
    a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (count_reg != '0) && (pos_reg < count_reg))
        else $error("result loaded outside the stored list");
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.seq_done |=> (count_reg == '0) && !ovf_reg)
        else $error("sequence state not cleared after results");
`endif

endmodule

// ----- rtl/pocs_ctrl.sv -----
// Controller: sequences rule writes, clearing, order check, swap passes and output.
module pocs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pocs_pkg::ctl_status_t st,
    output pocs_pkg::ctl_cmd_t    cmd
);

    pocs_pkg::state_t state_reg;
    pocs_pkg::state_t state_next;
    logic             swapped_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pocs_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A swap found in the final scan cycle of a pass still counts for it.
    assign swapped_now = st.swapped | (st.hit & ~st.row_skip);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            pocs_pkg::ST_CLEAR:
            begin
                cmd.mem_clr = 1'b1;
                if (st.clr_last)
                begin
                    state_next = pocs_pkg::ST_IDLE;
                end
            end
            pocs_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (st.in_valid)
                begin
                    case (st.in_cmd)
                        pocs_pkg::CMD_ADD_RULE:
                        begin
                            if (st.rule_ok)
                            begin
                                cmd.rule_rd = 1'b1;
                                state_next = pocs_pkg::ST_RULE_WR;
                            end
                        end
                        pocs_pkg::CMD_APPEND:
                        begin
                            cmd.append = 1'b1;
                            if (st.in_last)
                            begin
                                cmd.chk_init = 1'b1;
                                state_next = pocs_pkg::ST_CHK_ROW;
                            end
                        end
                        pocs_pkg::CMD_CLEAR:
                        begin
                            cmd.clr_init = 1'b1;
                            state_next = pocs_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            pocs_pkg::ST_RULE_WR:
            begin
                cmd.rule_wr = 1'b1;
                state_next = pocs_pkg::ST_IDLE;
            end
            pocs_pkg::ST_CHK_ROW:
            begin
                cmd.row_fetch = 1'b1;
                state_next = pocs_pkg::ST_CHK_SCAN;
            end
            pocs_pkg::ST_CHK_SCAN:
            begin
                if (!st.row_skip)
                begin
                    cmd.scan = 1'b1;
                end
                if (!st.row_skip && st.hit)
                begin
                    cmd.pass_init = 1'b1;
                    state_next = pocs_pkg::ST_SRT_ROW;
                end
                else if (st.row_skip || st.q_last)
                begin
                    if (st.pos_last)
                    begin
                        state_next = pocs_pkg::ST_MID;
                    end
                    else
                    begin
                        cmd.pos_next = 1'b1;
                        state_next = pocs_pkg::ST_CHK_ROW;
                    end
                end
            end
            pocs_pkg::ST_SRT_ROW:
            begin
                cmd.row_fetch = 1'b1;
                state_next = pocs_pkg::ST_SRT_SCAN;
            end
            pocs_pkg::ST_SRT_SCAN:
            begin
                if (!st.row_skip)
                begin
                    cmd.scan = 1'b1;
                end
                if (st.row_skip || st.q_last)
                begin
                    if (st.pos_last)
                    begin
                        cmd.pass_done = 1'b1;
                        if (swapped_now && !st.pass_limit)
                        begin
                            cmd.pass_init = 1'b1;
                            state_next = pocs_pkg::ST_SRT_ROW;
                        end
                        else
                        begin
                            cmd.set_unsettled = 1'b1;
                            cmd.unsettled_val = swapped_now;
                            state_next = pocs_pkg::ST_MID;
                        end
                    end
                    else
                    begin
                        cmd.pos_next = 1'b1;
                        state_next = pocs_pkg::ST_SRT_ROW;
                    end
                end
            end
            pocs_pkg::ST_MID:
            begin
                cmd.mid_fetch = 1'b1;
                cmd.out_init = 1'b1;
                state_next = pocs_pkg::ST_OUT;
            end
            pocs_pkg::ST_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (st.pos_last)
                    begin
                        cmd.seq_done = 1'b1;
                        state_next = pocs_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = pocs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/precedence_order_check_and_sort.sv -----
// An append stores one page, an add-rule reads one matrix row and then writes it back, and a clear
// sweeps the rule matrix, one matrix row a cycle. At the end of a sequence the order check, and then
// each swap pass, fetches the rule row of each position and scans it one rule bit a cycle, skipping
// an empty row; then the middle page is fetched and the n result items leave one a cycle while the
// receiver is ready; MAX_PASSES bounds the pass count. Reset clears the control state and then sweeps
// the rule matrix, during which no item is accepted.
module precedence_order_check_and_sort #(
    parameter int PAGE_RANGE = pocs_pkg::PAGE_RANGE_DEF,
    parameter int MAX_LEN = pocs_pkg::MAX_LEN_DEF,
    parameter int MAX_PASSES = pocs_pkg::MAX_PASSES_DEF
) (
    input logic         clk,
    input logic         rst_n,
    pocs_chan_if.sink   items,
    pocs_chan_if.source results
);

    pocs_pkg::ctl_cmd_t    cmd;
    pocs_pkg::ctl_status_t st;

    pocs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    pocs_dp #(
        .PAGE_RANGE (PAGE_RANGE),
        .MAX_LEN    (MAX_LEN),
        .MAX_PASSES (MAX_PASSES)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cmd     (cmd),
        .st      (st)
    );

endmodule

// ----- tb/pocs_checker.sv -----
// Checker that predicts the sorted page sequences and compares them with the block's results.
module pocs_checker (
    input  logic                clk,
    input  logic                in_valid,
    input  logic                in_ready,
    input  pocs_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  pocs_pkg::out_item_t out_data,
    output int                  fail_count,
    output int                  pending,
    output int                  results_seen,
    output int                  sequences_seen
);

    localparam int NPAGE = pocs_pkg::PAGE_RANGE_DEF;
    localparam int LEN = pocs_pkg::MAX_LEN_DEF;
    localparam int PASSES = pocs_pkg::MAX_PASSES_DEF;

    logic            rules [NPAGE][NPAGE];
    logic [pocs_pkg::PAGE_W-1:0] seq_pages [LEN];
    int              seq_len;
    logic            seq_dropped;
    pocs_pkg::out_item_t sorted_q [$];

    initial
    begin
        fail_count = 0;
        pending = 0;
        results_seen = 0;
        sequences_seen = 0;
        seq_len = 0;
        seq_dropped = 1'b0;
        for (int a = 0; a < NPAGE; a++)
            for (int b = 0; b < NPAGE; b++)
                rules[a][b] = 1'b0;
    end

    function automatic logic seq_in_order(int n);
        for (int i = 0; i < n; i++)
        begin
            if (rules[seq_pages[i]][seq_pages[i]])
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (rules[seq_pages[j]][seq_pages[i]])
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // The page at position i is latched once; the list itself moves as swaps happen.
    function automatic logic run_swap_pass(int n);
        logic            any_swap;
        logic [pocs_pkg::PAGE_W-1:0] p;
        logic [pocs_pkg::PAGE_W-1:0] t;
        any_swap = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            p = seq_pages[i];
            for (int q = 0; q < NPAGE; q++)
            begin
                if (!rules[p][q])
                    continue;
                for (int k = 0; k < i; k++)
                begin
                    if (seq_pages[k] == q)
                    begin
                        t = seq_pages[i];
                        seq_pages[i] = seq_pages[k];
                        seq_pages[k] = t;
                        any_swap = 1'b1;
                        break;
                    end
                end
            end
        end
        return any_swap;
    endfunction

    task automatic take_command(pocs_pkg::in_item_t it);
        logic      ordered;
        logic      still_swapping;
        int        passes;
        pocs_pkg::out_item_t r;
        ordered = 1'b1;
        still_swapping = 1'b0;
        passes = 0;
        case (it.command)
            pocs_pkg::CMD_ADD_RULE: rules[it.page_a][it.page_b] = 1'b1;
            pocs_pkg::CMD_CLEAR:
            begin
                for (int a = 0; a < NPAGE; a++)
                    for (int b = 0; b < NPAGE; b++)
                        rules[a][b] = 1'b0;
            end
            pocs_pkg::CMD_APPEND:
            begin
                if (seq_len < LEN)
                begin
                    seq_pages[seq_len] = it.page_a;
                    seq_len++;
                end
                else
                    seq_dropped = 1'b1;
                if (it.last)
                begin
                    ordered = seq_in_order(seq_len);
                    if (!ordered)
                    begin
                        do
                        begin
                            still_swapping = run_swap_pass(seq_len);
                            passes++;
                        end
                        while (still_swapping && passes < PASSES);
                    end
                    for (int k = 0; k < seq_len; k++)
                    begin
                        r.page = seq_pages[k];
                        r.end_of_run = (k + 1 == seq_len);
                        r.was_ordered = ordered;
                        r.middle_page = seq_pages[seq_len / 2];
                        r.overflow = seq_dropped;
                        r.unsettled = still_swapping;
                        sorted_q.insert(sorted_q.size(), r);
                    end
                    seq_len = 0;
                    seq_dropped = 1'b0;
                    sequences_seen++;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        pocs_pkg::out_item_t want;
        if (out_valid && out_ready)
        begin
            results_seen++;
            if (sorted_q.size() == 0)
            begin
                $error("result item with no page expected: page %0d", out_data.page);
                fail_count++;
            end
            else
            begin
                want = sorted_q.pop_front();
                if (want.page !== out_data.page)
                begin
                    $error("page: expected %0d, got %0d", want.page, out_data.page);
                    fail_count++;
                end
                if (want.end_of_run !== out_data.end_of_run)
                begin
                    $error("end_of_run: expected %0d, got %0d",
                           want.end_of_run, out_data.end_of_run);
                    fail_count++;
                end
                if (want.was_ordered !== out_data.was_ordered)
                begin
                    $error("was_ordered: expected %0d, got %0d",
                           want.was_ordered, out_data.was_ordered);
                    fail_count++;
                end
                if (want.middle_page !== out_data.middle_page)
                begin
                    $error("middle_page: expected %0d, got %0d",
                           want.middle_page, out_data.middle_page);
                    fail_count++;
                end
                if (want.overflow !== out_data.overflow)
                begin
                    $error("overflow: expected %0d, got %0d", want.overflow, out_data.overflow);
                    fail_count++;
                end
                if (want.unsettled !== out_data.unsettled)
                begin
                    $error("unsettled: expected %0d, got %0d",
                           want.unsettled, out_data.unsettled);
                    fail_count++;
                end
            end
        end
        if (in_valid && in_ready)
            take_command(in_data);
        pending = sorted_q.size();
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the testbench: clock, reset, stimulus, receiver stalls, watchdog and verdict.
module testbench;

    localparam int WATCHDOG_LIMIT = 600000;
    // The one command code that the block must ignore.
    localparam logic [pocs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    int   sender_idle_pct;
    int   stall_pct;
    int   items_sent;
    int   quiet_cycles;
    int   fail_count;
    int   pending;
    int   results_seen;
    int   sequences_seen;

    pocs_chan_if #(.item_t(pocs_pkg::in_item_t)) items_if ();
    pocs_chan_if #(.item_t(pocs_pkg::out_item_t)) results_if ();

    precedence_order_check_and_sort dut (
        .clk(clk),
        .rst_n(rst_n),
        .items(items_if.sink),
        .results(results_if.source)
    );

    pocs_checker u_checker (
        .clk(clk),
        .in_valid(items_if.valid),
        .in_ready(items_if.ready),
        .in_data(items_if.data),
        .out_valid(results_if.valid),
        .out_ready(results_if.ready),
        .out_data(results_if.data),
        .fail_count(fail_count),
        .pending(pending),
        .results_seen(results_seen),
        .sequences_seen(sequences_seen)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        items_if.valid = 1'b0;
        items_if.data = '0;
        results_if.ready = 1'b0;
        sender_idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        quiet_cycles = 0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
        results_if.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The sender idles phase by phase as the item count grows.
    task automatic send_item(logic [pocs_pkg::CMD_W-1:0] cmd, logic [pocs_pkg::PAGE_W-1:0] a,
                             logic [pocs_pkg::PAGE_W-1:0] b, logic last);
        pocs_pkg::in_item_t it;
        it.command = cmd;
        it.page_a = a;
        it.page_b = b;
        it.last = last;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            items_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        items_if.valid <= 1'b1;
        items_if.data <= it;
        do
            @(posedge clk);
        while (!items_if.ready);
        items_sent++;
    endtask

    task automatic drain_results();
        items_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [pocs_pkg::PAGE_W-1:0] pick_page();
        if ($urandom_range(9) < 8)
            return pocs_pkg::PAGE_W'($urandom_range(11));
        return pocs_pkg::PAGE_W'($urandom);
    endfunction

    task automatic set_phase();
        if (items_sent < 120)
        begin
            sender_idle_pct = 0;
            stall_pct = 0;
        end
        else if (items_sent < 240)
        begin
            sender_idle_pct = 64;
            stall_pct = 0;
        end
        else if (items_sent < 360)
        begin
            sender_idle_pct = 0;
            stall_pct = 64;
        end
        else
        begin
            sender_idle_pct = 31;
            stall_pct = 31;
        end
    endtask

    initial
    begin
        int len;
        int nrules;
        int roll;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: extreme pages, every command, and the corner cases.
        send_item(pocs_pkg::CMD_CLEAR, 7'd0, 7'd0, 1'b1);
        send_item(pocs_pkg::CMD_ADD_RULE, 7'd0, 7'd127, 1'b1);
        send_item(pocs_pkg::CMD_ADD_RULE, 7'd127, 7'd0, 1'b0);
        send_item(pocs_pkg::CMD_ADD_RULE, 7'd0, 7'd127, 1'b0);
        send_item(CMD_UNUSED, 7'd127, 7'd127, 1'b1);
        send_item(pocs_pkg::CMD_APPEND, 7'd127, 7'd127, 1'b0);
        send_item(pocs_pkg::CMD_APPEND, 7'd0, 7'd0, 1'b1);
        send_item(pocs_pkg::CMD_ADD_RULE, 7'd5, 7'd5, 1'b0);
        send_item(pocs_pkg::CMD_APPEND, 7'd4, 7'd0, 1'b0);
        send_item(pocs_pkg::CMD_APPEND, 7'd5, 7'd0, 1'b1);
        send_item(pocs_pkg::CMD_APPEND, 7'd1, 7'd0, 1'b0);
        send_item(pocs_pkg::CMD_CLEAR, 7'd0, 7'd0, 1'b0);
        send_item(pocs_pkg::CMD_APPEND, 7'd2, 7'd0, 1'b0);
        send_item(pocs_pkg::CMD_APPEND, 7'd3, 7'd0, 1'b1);
        send_item(pocs_pkg::CMD_ADD_RULE, 7'd1, 7'd2, 1'b0);
        send_item(pocs_pkg::CMD_ADD_RULE, 7'd2, 7'd1, 1'b0);
        send_item(pocs_pkg::CMD_APPEND, 7'd1, 7'd0, 1'b0);
        send_item(pocs_pkg::CMD_APPEND, 7'd2, 7'd0, 1'b0);
        send_item(pocs_pkg::CMD_APPEND, 7'd3, 7'd0, 1'b1);
        send_item(pocs_pkg::CMD_CLEAR, 7'd127, 7'd127, 1'b0);
        send_item(pocs_pkg::CMD_ADD_RULE, 7'd3, 7'd1, 1'b0);
        send_item(pocs_pkg::CMD_APPEND, 7'd1, 7'd0, 1'b0);
        send_item(pocs_pkg::CMD_APPEND, 7'd3, 7'd0, 1'b1);
        drain_results();

        // Random part: mostly well-formed rule sets and sequences, some noise.
        while (items_sent < 480)
        begin
            set_phase();
            if ($urandom_range(9) == 0)
                send_item(pocs_pkg::CMD_CLEAR, pocs_pkg::PAGE_W'($urandom),
                          pocs_pkg::PAGE_W'($urandom), 1'($urandom));
            nrules = $urandom_range(5);
            for (int r = 0; r < nrules; r++)
                send_item(pocs_pkg::CMD_ADD_RULE, pick_page(), pick_page(), 1'($urandom));
            roll = $urandom_range(99);
            if (roll < 4)
                len = $urandom_range(36, 31);
            else if (roll < 15)
                len = $urandom_range(16, 9);
            else
                len = $urandom_range(8, 1);
            for (int k = 0; k < len; k++)
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                    send_item(CMD_UNUSED, pocs_pkg::PAGE_W'($urandom),
                              pocs_pkg::PAGE_W'($urandom), 1'($urandom));
                else if (roll < 5)
                    send_item(pocs_pkg::CMD_CLEAR, 7'd0, 7'd0, 1'($urandom));
                else if (roll < 8)
                    send_item(pocs_pkg::CMD_ADD_RULE, pick_page(), pick_page(), 1'($urandom));
                send_item(pocs_pkg::CMD_APPEND, pick_page(), pocs_pkg::PAGE_W'($urandom),
                          k == len - 1);
            end
            if ($urandom_range(19) == 0)
                drain_results();
        end

        drain_results();
        repeat (300) @(posedge clk);
        $display("Sent %0d items in %0d sequences; checked %0d result items.",
                 items_sent, sequences_seen, results_seen);
        $display("Phases covered free flow, sender gaps, receiver stalls and both together.");
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/pocs_pkg.sv
rtl/pocs_chan_if.sv
rtl/pocs_dp.sv
rtl/pocs_ctrl.sv
rtl/precedence_order_check_and_sort.sv
tb/pocs_checker.sv
tb/testbench.sv
